// ===== hdl/isp_programmer_command_engine_assert.svh =====
// ---------------------------------------------------------------------------
// isp_programmer_command_engine_assert.svh
// Assertion macros for the programmer command engine; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ISP_PROGRAMMER_COMMAND_ENGINE_ASSERT_SVH
`define ISP_PROGRAMMER_COMMAND_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// checked only outside reset
`define ISP_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("isp command engine assertion failed");

// checked also during reset
`define ISP_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("isp command engine assertion failed");

`else

`define ISP_ASSERT(lbl, clk_s, rstn_s, prop)
`define ISP_ASSERT_ALWAYS(lbl, clk_s, prop)

`endif

`endif

// ===== hdl/isp_cmd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// isp_cmd_pkg
// Types, codes and helpers shared by the programmer command engine.
// ---------------------------------------------------------------------------
package isp_cmd_pkg;

  localparam logic [3:0] CHUNK_BYTES = 4'd8;

  // item kinds
  localparam logic [1:0] KIND_SETUP = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // setup function codes
  localparam logic [7:0] FC_CONNECT    = 8'd1;
  localparam logic [7:0] FC_DISCONNECT = 8'd2;
  localparam logic [7:0] FC_TRANSMIT   = 8'd3;
  localparam logic [7:0] FC_READ_FLASH = 8'd4;
  localparam logic [7:0] FC_ENABLE     = 8'd5;
  localparam logic [7:0] FC_WRITE_FLASH = 8'd6;
  localparam logic [7:0] FC_READ_EEP   = 8'd7;
  localparam logic [7:0] FC_WRITE_EEP  = 8'd8;
  localparam logic [7:0] FC_LONG_ADDR  = 8'd9;
  localparam logic [7:0] FC_SET_SCK    = 8'd10;
  localparam logic [7:0] FC_CAPS       = 8'd127;

  // transmit query bytes
  localparam logic [7:0] QB_SIG     = 8'h30;
  localparam logic [7:0] QB_FUSE_LO = 8'h50;
  localparam logic [7:0] QB_FUSE_HI = 8'h58;
  localparam logic [7:0] QB_EXT     = 8'h08;
  localparam logic [7:0] QB_ZERO    = 8'h00;
  localparam logic [7:0] LEN_DATA   = 8'hff;

  // link states
  localparam logic [1:0] LINK_NONE = 2'd0;
  localparam logic [1:0] LINK_CONN = 2'd1;
  localparam logic [1:0] LINK_PROG = 2'd2;

  // transfer states
  localparam logic [2:0] XS_IDLE   = 3'd0;
  localparam logic [2:0] XS_RFLASH = 3'd1;
  localparam logic [2:0] XS_REEP   = 3'd2;
  localparam logic [2:0] XS_WFLASH = 3'd3;
  localparam logic [2:0] XS_WEEP   = 3'd4;

  // memory operations
  localparam logic [2:0] MOP_NONE   = 3'd0;
  localparam logic [2:0] MOP_RFLASH = 3'd1;
  localparam logic [2:0] MOP_REEP   = 3'd2;
  localparam logic [2:0] MOP_WFLASH = 3'd3;
  localparam logic [2:0] MOP_WEEP   = 3'd4;

  // chunk status
  localparam logic [1:0] CS_REJECT = 2'd0;
  localparam logic [1:0] CS_OK     = 2'd1;
  localparam logic [1:0] CS_DONE   = 2'd2;

  // register indexes
  localparam logic [2:0] REG_SIG      = 3'd0;
  localparam logic [2:0] REG_FUSE_LO  = 3'd1;
  localparam logic [2:0] REG_FUSE_HI  = 3'd2;
  localparam logic [2:0] REG_FUSE_EXT = 3'd3;
  localparam logic [2:0] REG_LOCK     = 3'd4;

  typedef struct packed {
    logic [23:0] signature_bytes;
    logic [7:0]  fuse_low;
    logic [7:0]  fuse_high;
    logic [7:0]  fuse_extended;
    logic [7:0]  lock_byte;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [7:0]  func_code;
    logic [47:0] setup_args;
    logic [3:0]  chunk_len;
    logic [63:0] chunk_data;
  } item_t;

  typedef struct packed {
    logic [31:0] reply_bytes;
    logic [7:0]  reply_len;
    logic [1:0]  chunk_status;
    logic [2:0]  mem_op;
    logic [31:0] mem_address;
    logic [3:0]  mem_len;
    logic [63:0] mem_data;
  } res_t;

  function automatic logic [63:0] byte_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (4'(i) < len) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage

// ===== hdl/isp_cmd_regs.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// isp_cmd_regs
// Configuration registers behind the APB-style port.
// ---------------------------------------------------------------------------
module isp_cmd_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output isp_cmd_pkg::cfg_t    cfg
);

  isp_cmd_pkg::cfg_t cfg_r;
  logic [2:0]        idx;
  logic              wr_en;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        isp_cmd_pkg::REG_SIG:      cfg_r.signature_bytes <= pwdata[23:0];
        isp_cmd_pkg::REG_FUSE_LO:  cfg_r.fuse_low        <= pwdata[7:0];
        isp_cmd_pkg::REG_FUSE_HI:  cfg_r.fuse_high       <= pwdata[7:0];
        isp_cmd_pkg::REG_FUSE_EXT: cfg_r.fuse_extended   <= pwdata[7:0];
        isp_cmd_pkg::REG_LOCK:     cfg_r.lock_byte       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      isp_cmd_pkg::REG_SIG:      prdata = {8'h00, cfg_r.signature_bytes};
      isp_cmd_pkg::REG_FUSE_LO:  prdata = {24'h0, cfg_r.fuse_low};
      isp_cmd_pkg::REG_FUSE_HI:  prdata = {24'h0, cfg_r.fuse_high};
      isp_cmd_pkg::REG_FUSE_EXT: prdata = {24'h0, cfg_r.fuse_extended};
      isp_cmd_pkg::REG_LOCK:     prdata = {24'h0, cfg_r.lock_byte};
      default:                   prdata = '0;
    endcase
  end

endmodule

// ===== hdl/isp_cmd_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// isp_cmd_core
// Command decode and protocol state: link, transfer, address mode, address
// and byte count. State advances once per processed transaction.
// ---------------------------------------------------------------------------
module isp_cmd_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  isp_cmd_pkg::item_t   item,
  input  isp_cmd_pkg::cfg_t    cfg,
  output isp_cmd_pkg::res_t    res
);

  logic [1:0]  link_r,  link_nxt;
  logic [2:0]  xfer_r,  xfer_nxt;
  logic        lam_r,   lam_nxt;
  logic [31:0] addr_r,  addr_nxt;
  logic [15:0] rem_r,   rem_nxt;

  logic [7:0]  b2, b3, b4;
  logic [7:0]  last;
  logic        q_hit;
  logic [3:0]  len;
  logic [31:0] addr_inc;
  logic [15:0] rem_dec;
  logic        finished;

  assign b2 = item.setup_args[7:0];
  assign b3 = item.setup_args[15:8];
  assign b4 = item.setup_args[23:16];

  assign len = (item.chunk_len > isp_cmd_pkg::CHUNK_BYTES) ?
               isp_cmd_pkg::CHUNK_BYTES : item.chunk_len;
  assign addr_inc = addr_r + {28'h0, len};
  assign rem_dec  = ({12'h0, len} >= rem_r) ? 16'h0 : rem_r - {12'h0, len};

  // transmit query: last reply byte
  always_comb begin
    q_hit = 1'b1;
    last  = '0;
    if (b2 == isp_cmd_pkg::QB_SIG && b3 == isp_cmd_pkg::QB_ZERO && b4 < 8'd3) begin
      case (b4[1:0])
        2'd0:    last = cfg.signature_bytes[7:0];
        2'd1:    last = cfg.signature_bytes[15:8];
        default: last = cfg.signature_bytes[23:16];
      endcase
    end else if (b2 == isp_cmd_pkg::QB_FUSE_LO && b3 == isp_cmd_pkg::QB_ZERO) begin
      last = cfg.fuse_low;
    end else if (b2 == isp_cmd_pkg::QB_FUSE_HI && b3 == isp_cmd_pkg::QB_EXT) begin
      last = cfg.fuse_high;
    end else if (b2 == isp_cmd_pkg::QB_FUSE_LO && b3 == isp_cmd_pkg::QB_EXT) begin
      last = cfg.fuse_extended;
    end else if (b2 == isp_cmd_pkg::QB_FUSE_HI && b3 == isp_cmd_pkg::QB_ZERO) begin
      last = cfg.lock_byte;
    end else begin
      q_hit = 1'b0;
    end
  end

  always_comb begin
    link_nxt = link_r;
    xfer_nxt = xfer_r;
    lam_nxt  = lam_r;
    addr_nxt = addr_r;
    rem_nxt  = rem_r;
    res      = '0;
    finished = 1'b0;
    unique case (item.item_kind)
      isp_cmd_pkg::KIND_SETUP: begin
        unique case (item.func_code) inside
          isp_cmd_pkg::FC_CONNECT: begin
            link_nxt = isp_cmd_pkg::LINK_CONN;
            lam_nxt  = 1'b0;
          end
          isp_cmd_pkg::FC_DISCONNECT: begin
            link_nxt = isp_cmd_pkg::LINK_NONE;
          end
          isp_cmd_pkg::FC_TRANSMIT: begin
            if (q_hit) begin
              res.reply_bytes = {last, b4, b3, b2};
              res.reply_len   = 8'd4;
            end
          end
          isp_cmd_pkg::FC_READ_FLASH, isp_cmd_pkg::FC_READ_EEP: begin
            if (link_r != isp_cmd_pkg::LINK_NONE) begin
              if (!lam_r) addr_nxt = {16'h0, item.setup_args[15:0]};
              rem_nxt  = item.setup_args[47:32];
              xfer_nxt = (item.func_code == isp_cmd_pkg::FC_READ_FLASH) ?
                         isp_cmd_pkg::XS_RFLASH : isp_cmd_pkg::XS_REEP;
              res.reply_len = isp_cmd_pkg::LEN_DATA;
            end
          end
          isp_cmd_pkg::FC_ENABLE: begin
            if (link_r == isp_cmd_pkg::LINK_CONN) begin
              link_nxt = isp_cmd_pkg::LINK_PROG;
            end else begin
              res.reply_bytes = 32'd1;
            end
            res.reply_len = 8'd1;
          end
          isp_cmd_pkg::FC_WRITE_FLASH, isp_cmd_pkg::FC_WRITE_EEP: begin
            if (link_r == isp_cmd_pkg::LINK_PROG) begin
              if (!lam_r) addr_nxt = {16'h0, item.setup_args[15:0]};
              rem_nxt  = item.setup_args[47:32];
              xfer_nxt = (item.func_code == isp_cmd_pkg::FC_WRITE_FLASH) ?
                         isp_cmd_pkg::XS_WFLASH : isp_cmd_pkg::XS_WEEP;
              res.reply_len = isp_cmd_pkg::LEN_DATA;
            end
          end
          isp_cmd_pkg::FC_LONG_ADDR: begin
            if (link_r != isp_cmd_pkg::LINK_NONE) begin
              lam_nxt  = 1'b1;
              addr_nxt = item.setup_args[31:0];
            end
          end
          isp_cmd_pkg::FC_SET_SCK: res.reply_len = 8'd1;
          isp_cmd_pkg::FC_CAPS:    res.reply_len = 8'd4;
          default: ;
        endcase
      end
      isp_cmd_pkg::KIND_READ: begin
        if (xfer_r == isp_cmd_pkg::XS_RFLASH || xfer_r == isp_cmd_pkg::XS_REEP) begin
          res.mem_op = (xfer_r == isp_cmd_pkg::XS_RFLASH) ?
                       isp_cmd_pkg::MOP_RFLASH : isp_cmd_pkg::MOP_REEP;
          finished        = len < isp_cmd_pkg::CHUNK_BYTES;
          res.mem_address = addr_r;
          res.mem_len     = len;
          addr_nxt        = addr_inc;
          res.chunk_status = finished ? isp_cmd_pkg::CS_DONE : isp_cmd_pkg::CS_OK;
          if (finished) xfer_nxt = isp_cmd_pkg::XS_IDLE;
        end
      end
      isp_cmd_pkg::KIND_WRITE: begin
        if (xfer_r == isp_cmd_pkg::XS_WFLASH || xfer_r == isp_cmd_pkg::XS_WEEP) begin
          res.mem_op = (xfer_r == isp_cmd_pkg::XS_WFLASH) ?
                       isp_cmd_pkg::MOP_WFLASH : isp_cmd_pkg::MOP_WEEP;
          res.mem_data    = item.chunk_data & isp_cmd_pkg::byte_mask(len);
          rem_nxt         = rem_dec;
          finished        = rem_dec == 16'h0;
          res.mem_address = addr_r;
          res.mem_len     = len;
          addr_nxt        = addr_inc;
          res.chunk_status = finished ? isp_cmd_pkg::CS_DONE : isp_cmd_pkg::CS_OK;
          if (finished) xfer_nxt = isp_cmd_pkg::XS_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r <= isp_cmd_pkg::LINK_NONE;
      xfer_r <= isp_cmd_pkg::XS_IDLE;
      lam_r  <= 1'b0;
      addr_r <= '0;
      rem_r  <= '0;
    end else if (fire) begin
      link_r <= link_nxt;
      xfer_r <= xfer_nxt;
      lam_r  <= lam_nxt;
      addr_r <= addr_nxt;
      rem_r  <= rem_nxt;
    end
  end

endmodule

// ===== hdl/isp_programmer_command_engine.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// isp_programmer_command_engine
// Command engine of an in-system programmer: setup packets, read and write
// chunks, one result transaction per input transaction.
//
// Input channel in_*: one transaction per setup packet or chunk, taken when
// in_valid is high and in_stall low. Result channel out_*: one transaction
// per input, same order, held while out_stall is high.
// Configuration: APB-style port, registers at byte addresses 0,4,..,16;
// pready is always high, writes land at the access cycle.
// Path: input register, then decode and state update into the result
// register; out_valid rises when the result register loads.
// Throughput: one transaction per cycle while out_stall is low; the single
// decode stage between the input and result registers sets it.
// Stalls: with out_stall high the result register holds, the input
// register still fills once, then in_stall rises.
// Reset: synchronous; link unconnected, transfer idle, address, byte count
// and all configuration registers cleared, both channels empty.
// ---------------------------------------------------------------------------
`include "isp_programmer_command_engine_assert.svh"

module isp_programmer_command_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_item_kind,
  input  logic [7:0]  in_func_code,
  input  logic [47:0] in_setup_args,
  input  logic [3:0]  in_chunk_len,
  input  logic [63:0] in_chunk_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_reply_bytes,
  output logic [7:0]  out_reply_len,
  output logic [1:0]  out_chunk_status,
  output logic [2:0]  out_mem_op,
  output logic [31:0] out_mem_address,
  output logic [3:0]  out_mem_len,
  output logic [63:0] out_mem_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  isp_cmd_pkg::cfg_t  cfg;
  isp_cmd_pkg::item_t item_r;
  isp_cmd_pkg::res_t  res;
  isp_cmd_pkg::res_t  res_r;
  logic               in_valid_r;
  logic               out_valid_r;
  logic               advance;
  logic               load_in;

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign load_in  = in_valid && !in_stall;

  isp_cmd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  isp_cmd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_in || advance) in_valid_r <= load_in;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      item_r.item_kind  <= in_item_kind;
      item_r.func_code  <= in_func_code;
      item_r.setup_args <= in_setup_args;
      item_r.chunk_len  <= in_chunk_len;
      item_r.chunk_data <= in_chunk_data;
    end
    if (advance) res_r <= res;
  end

  assign out_valid        = out_valid_r;
  assign out_reply_bytes  = res_r.reply_bytes;
  assign out_reply_len    = res_r.reply_len;
  assign out_chunk_status = res_r.chunk_status;
  assign out_mem_op       = res_r.mem_op;
  assign out_mem_address  = res_r.mem_address;
  assign out_mem_len      = res_r.mem_len;
  assign out_mem_data     = res_r.mem_data;

  `ISP_ASSERT_ALWAYS(a_stall_needs_item, clk, in_stall |-> in_valid_r)
  `ISP_ASSERT(a_idle_access_zero, clk, rst_n, (out_valid_r && res_r.mem_op == isp_cmd_pkg::MOP_NONE) |-> (res_r.mem_address == 32'h0 && res_r.mem_len == 4'h0 && res_r.mem_data == 64'h0))
  `ISP_ASSERT(a_status_has_access, clk, rst_n, (out_valid_r && res_r.chunk_status != isp_cmd_pkg::CS_REJECT) |-> (res_r.mem_op != isp_cmd_pkg::MOP_NONE))
  `ISP_ASSERT(a_reply_no_access, clk, rst_n, (out_valid_r && res_r.reply_len != 8'h0) |-> (res_r.chunk_status == isp_cmd_pkg::CS_REJECT && res_r.mem_op == isp_cmd_pkg::MOP_NONE))

endmodule
